// ----- hdl/tba_pkg.sv -----
package tba_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int ADDR_BITS_DEF = 28;
    localparam int FIELD_W       = 28;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_DECIDE,
        S_FREE_RD,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE,
        S_SUM_RD,
        S_SUM,
        S_DONE
    } state_t;

endpackage

// ----- hdl/tba_ram.sv -----
module tba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/two_ended_buffer_allocator.sv -----
// two-ended buffer allocator, one transaction in flight at a time
// an allocate walks the table (S_SCAN), decides, then sums the table (S_SUM) before done;
//   a free also rereads the freed slot and, if it moves a mark, walks the merge states too
// every table walk goes through the one registered slot ram read port
// busy is high until the cycle done is strobed
// reset: asynchronous, marks and heap size go to zero, table emptied; receiver cannot stall
module two_ended_buffer_allocator #(
    parameter int SLOTS = tba_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tba_pkg::FIELD_W-1:0] cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [tba_pkg::FIELD_W-1:0] size,
    input  logic                        aligned,
    input  logic [tba_pkg::FIELD_W-1:0] free_offset,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [tba_pkg::FIELD_W-1:0] offset,
    output logic [tba_pkg::FIELD_W-1:0] free_bytes,
    output logic [tba_pkg::FIELD_W-1:0] used_bytes,
    output logic [tba_pkg::FIELD_W-1:0] fragmented_bytes
);
    import tba_pkg::*;

    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW;
    localparam int RW = 1 + 2 * ADDR_BITS;

    // slot payload ram: {from_top, start, length}
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    tba_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic                 rd_top;
    logic [ADDR_BITS-1:0] rd_start;
    logic [ADDR_BITS-1:0] rd_len;
    assign rd_top   = ram_rdata[RW-1];
    assign rd_start = ram_rdata[2*ADDR_BITS-1:ADDR_BITS];
    assign rd_len   = ram_rdata[ADDR_BITS-1:0];

    state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] low_reg, low_next, high_reg, high_next;
    logic [SLOTS-1:0] valid_reg, valid_next, inuse_reg, inuse_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             op_reg, top_reg;
    logic [ADDR_BITS-1:0] size_reg, foff_reg;
    logic             hit_reg, hit_next;
    logic [IW-1:0]    hit_idx_reg, hit_idx_next;
    logic [ADDR_BITS-1:0] hit_start_reg, hit_start_next;
    logic [ADDR_BITS-1:0] used_reg, used_next, frag_reg, frag_next;
    logic [1:0]       st_reg, st_next;
    logic [ADDR_BITS-1:0] off_reg, off_next;
    logic             done_reg, done_next;

    // lowest empty slot, priority encode over valid bits
    logic          empty_any;
    logic [IW-1:0] empty_idx;
    always_comb
    begin
        empty_any = 1'b0;
        empty_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                empty_any = 1'b1;
                empty_idx = IW'(i);
            end
        end
    end

    logic [IW-1:0] cur;
    assign cur = idx_reg[IW-1:0];
    logic [ADDR_BITS-1:0] space;
    assign space = (high_reg >= low_reg) ? (high_reg - low_reg) : '0;
    logic [ADDR_BITS:0] rd_end;
    assign rd_end = {1'b0, rd_start} + {1'b0, rd_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            low_reg   <= '0;
            high_reg  <= '0;
            valid_reg <= '0;
            inuse_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            low_reg   <= '0;
            high_reg  <= cfg_wdata[ADDR_BITS-1:0];
            valid_reg <= '0;
            inuse_reg <= '0;
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            valid_reg <= valid_next;
            inuse_reg <= inuse_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_start_reg <= hit_start_next;
        used_reg      <= used_next;
        frag_reg      <= frag_next;
        st_reg        <= st_next;
        off_reg       <= off_next;
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= op;
            top_reg  <= aligned;
            size_reg <= size[ADDR_BITS-1:0];
            foff_reg <= free_offset[ADDR_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        valid_next     = valid_reg;
        inuse_next     = inuse_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_start_next = hit_start_reg;
        used_next      = used_reg;
        frag_next      = frag_reg;
        st_next        = st_reg;
        off_next       = off_reg;
        done_next      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = empty_idx;
        ram_wdata      = {top_reg, high_reg - size_reg, size_reg};
        ram_raddr      = cur;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    st_next    = ST_OK;
                    off_next   = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN;
            end
            // walk the table for a reuse match (allocate) or an offset match (free)
            S_SCAN:
            begin
                if (!hit_reg && valid_reg[cur] &&
                    ((op_reg == OP_ALLOC && !inuse_reg[cur] && rd_len == size_reg) ||
                     (op_reg == OP_FREE && inuse_reg[cur] && rd_start == foff_reg)))
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cur;
                    hit_start_next = rd_start;
                end
                if (idx_reg == CW'(SLOTS - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                idx_next = '0;
                if (op_reg == OP_ALLOC)
                begin
                    state_next = S_SUM_RD;
                    if (hit_reg)
                    begin
                        inuse_next[hit_idx_reg] = 1'b1;
                        off_next = hit_start_reg;
                    end
                    else if (size_reg > space)
                    begin
                        st_next = ST_NO_SPACE;
                    end
                    else if (!empty_any)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        valid_next[empty_idx] = 1'b1;
                        inuse_next[empty_idx] = 1'b1;
                        if (top_reg)
                        begin
                            high_next = high_reg - size_reg;
                            off_next  = high_reg - size_reg;
                        end
                        else
                        begin
                            ram_wdata = {top_reg, low_reg, size_reg};
                            low_next  = low_reg + size_reg;
                            off_next  = low_reg;
                        end
                    end
                end
                else if (!hit_reg)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    ram_raddr  = hit_idx_reg;
                    state_next = S_FREE_RD;
                end
            end
            S_FREE_RD:
            begin
                ram_raddr  = hit_idx_reg;
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                inuse_next[hit_idx_reg] = 1'b0;
                idx_next = '0;
                if (rd_top && rd_start == high_reg)
                begin
                    high_next = high_reg + rd_len;
                    valid_next[hit_idx_reg] = 1'b0;
                    state_next = S_MERGE_RD;
                end
                else if (rd_end == {1'b0, low_reg})
                begin
                    low_next = low_reg - rd_len;
                    valid_next[hit_idx_reg] = 1'b0;
                    state_next = S_MERGE_RD;
                end
                else
                begin
                    state_next = S_SUM_RD;
                end
            end
            S_MERGE_RD:
            begin
                state_next = S_MERGE;
            end
            // restart from slot zero each time a freed slot folds into a mark
            S_MERGE:
            begin
                if (valid_reg[cur] && !inuse_reg[cur] && rd_top && rd_start == high_reg)
                begin
                    high_next = high_reg + rd_len;
                    valid_next[cur] = 1'b0;
                    idx_next = '0;
                    state_next = S_MERGE_RD;
                end
                else if (valid_reg[cur] && !inuse_reg[cur] && !rd_top &&
                         rd_end == {1'b0, low_reg})
                begin
                    low_next = low_reg - rd_len;
                    valid_next[cur] = 1'b0;
                    idx_next = '0;
                    state_next = S_MERGE_RD;
                end
                else if (idx_reg == CW'(SLOTS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MERGE_RD;
                end
            end
            S_SUM_RD:
            begin
                if (idx_reg == '0)
                begin
                    used_next = '0;
                    frag_next = '0;
                end
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (valid_reg[cur])
                begin
                    if (inuse_reg[cur])
                    begin
                        used_next = used_reg + rd_len;
                    end
                    else
                    begin
                        frag_next = frag_reg + rd_len;
                    end
                end
                if (idx_reg == CW'(SLOTS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SUM_RD;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output registers, loaded in S_DONE and held until the next transaction finishes
    logic [1:0]           o_st_reg;
    logic [ADDR_BITS-1:0] o_off_reg, o_free_reg, o_used_reg, o_frag_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            o_st_reg   <= st_reg;
            o_off_reg  <= (st_reg == ST_OK) ? off_reg : '0;
            o_free_reg <= space;
            o_used_reg <= used_reg;
            o_frag_reg <= frag_reg;
        end
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign status           = o_st_reg;
    assign offset           = FIELD_W'(o_off_reg);
    assign free_bytes       = FIELD_W'(o_free_reg);
    assign used_bytes       = FIELD_W'(o_used_reg);
    assign fragmented_bytes = FIELD_W'(o_frag_reg);

    a_inuse_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (inuse_reg & ~valid_reg) == '0)
        else $error("in-use slot not valid");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("done while busy");
endmodule
